>>> design/mexp_pkg.sv
package mexp_pkg;

  // Width of the payload and configuration fields on the ports
  localparam int FIELD_W = 64;
  // Default working operand width
  localparam int OPERAND_BITS_DEF = 64;

  // Configuration register indexes
  localparam logic REG_MODULUS  = 1'b0;
  localparam logic REG_EXPONENT = 1'b1;

  // Datapath operations
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,       // latch base and modulus, clear accumulator
    DP_RED,        // one reduction step: acc = 2*acc + base bit mod m
    DP_RED_DONE,   // reduced base becomes b and the running value
    DP_MUL_START,  // load multiplicand and multiplier, clear accumulator
    DP_MUL_STEP,   // one bit of the shift-and-add modular product
    DP_MUL_DONE,   // product becomes the running value
    DP_OUT         // write the result register
  } dp_op_e;

  // Result selection
  typedef enum logic [1:0] {
    RES_RUN,
    RES_ZERO,
    RES_ONE
  } res_sel_e;

  typedef struct packed {
    dp_op_e   op;
    logic     sq;   // square (running value by itself) rather than multiply by b
    res_sel_e res;
  } dp_cmd_t;

  typedef struct packed {
    logic m_zero;
  } dp_sts_t;

endpackage

>>> design/mexp_datapath.sv
module mexp_datapath
  import mexp_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic [OPERAND_BITS-1:0] base_i,
  input  logic [OPERAND_BITS-1:0] modulus_i,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  output logic [OPERAND_BITS-1:0] power_o
);

  localparam int W = OPERAND_BITS;

  logic [W-1:0] m_q;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] sh_q;
  logic [W-1:0] opa_q;
  logic [W-1:0] b_q;
  logic [W-1:0] run_q;
  logic [W-1:0] pow_q;

  logic         in_bit;
  logic [W-1:0] addend;
  logic [W:0]   dbl;
  logic [W-1:0] dbl_r;
  logic [W:0]   sum;

  // One step: double plus incoming bit, reduce, then add the addend and reduce
  always_comb begin
    in_bit = (cmd_i.op == DP_RED) ? sh_q[W-1] : 1'b0;
    addend = ((cmd_i.op == DP_MUL_STEP) && sh_q[W-1]) ? opa_q : '0;
    dbl    = {acc_q, in_bit};
    dbl_r  = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : dbl[W-1:0];
    sum    = {1'b0, dbl_r} + {1'b0, addend};
    acc_d  = (sum >= {1'b0, m_q}) ? W'(sum - {1'b0, m_q}) : sum[W-1:0];
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        sh_q  <= base_i;
        m_q   <= modulus_i;
        acc_q <= '0;
      end
      DP_RED, DP_MUL_STEP: begin
        acc_q <= acc_d;
        sh_q  <= {sh_q[W-2:0], 1'b0};
      end
      DP_RED_DONE: begin
        b_q   <= acc_q;
        run_q <= acc_q;
      end
      DP_MUL_START: begin
        opa_q <= cmd_i.sq ? run_q : b_q;
        sh_q  <= run_q;
        acc_q <= '0;
      end
      DP_MUL_DONE: begin
        run_q <= acc_q;
      end
      DP_OUT: begin
        case (cmd_i.res)
          RES_RUN:  pow_q <= run_q;
          RES_ZERO: pow_q <= '0;
          RES_ONE:  pow_q <= (m_q == W'(1)) ? '0 : W'(1);
          default:  pow_q <= '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign sts_o.m_zero = (m_q == '0);
  assign power_o      = pow_q;

endmodule

>>> design/mexp_ctrl.sv
module mexp_ctrl
  import mexp_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  logic [OPERAND_BITS-1:0] exponent_i,
  input  dp_sts_t                 sts_i,
  output dp_cmd_t                 cmd_o
);

  localparam int W  = OPERAND_BITS;
  localparam int CW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_RED_END,
    S_NORM,
    S_SCAN,
    S_SQ_LOAD,
    S_SQ_RUN,
    S_SQ_END,
    S_MU_LOAD,
    S_MU_RUN,
    S_MU_END,
    S_FINISH
  } state_e;

  state_e        state_q, state_d;
  logic [W-1:0]  ex_q, ex_d;
  logic [CW-1:0] cnt_q, cnt_d;    // exponent bits not yet consumed
  logic [CW-1:0] bcnt_q, bcnt_d;  // steps left in a reduction or product
  logic          ezero_q, ezero_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    ex_d        = ex_q;
    cnt_d       = cnt_q;
    bcnt_d      = bcnt_q;
    ezero_d     = ezero_q;
    out_valid_d = out_valid_q;
    cmd_o       = '{op: DP_NOP, sq: 1'b0, res: RES_RUN};

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          ex_d     = exponent_i;
          ezero_d  = (exponent_i == '0);
          bcnt_d   = CW'(W);
          cnt_d    = CW'(W);
          state_d  = S_REDUCE;
        end
      end
      // base mod m, one base bit per cycle
      S_REDUCE: begin
        cmd_o.op = DP_RED;
        bcnt_d   = bcnt_q - 1'b1;
        if (bcnt_q == CW'(1)) state_d = S_RED_END;
      end
      S_RED_END: begin
        cmd_o.op = DP_RED_DONE;
        state_d  = ezero_q ? S_FINISH : S_NORM;
      end
      // skip leading zeros and the leading one
      S_NORM: begin
        ex_d  = {ex_q[W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (ex_q[W-1]) state_d = S_SCAN;
      end
      S_SCAN: begin
        state_d = (cnt_q == '0) ? S_FINISH : S_SQ_LOAD;
      end
      S_SQ_LOAD: begin
        cmd_o.op = DP_MUL_START;
        cmd_o.sq = 1'b1;
        bcnt_d   = CW'(W);
        state_d  = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        cmd_o.op = DP_MUL_STEP;
        bcnt_d   = bcnt_q - 1'b1;
        if (bcnt_q == CW'(1)) state_d = S_SQ_END;
      end
      S_SQ_END: begin
        cmd_o.op = DP_MUL_DONE;
        if (ex_q[W-1]) begin
          state_d = S_MU_LOAD;
        end else begin
          ex_d    = {ex_q[W-2:0], 1'b0};
          cnt_d   = cnt_q - 1'b1;
          state_d = S_SCAN;
        end
      end
      S_MU_LOAD: begin
        cmd_o.op = DP_MUL_START;
        bcnt_d   = CW'(W);
        state_d  = S_MU_RUN;
      end
      S_MU_RUN: begin
        cmd_o.op = DP_MUL_STEP;
        bcnt_d   = bcnt_q - 1'b1;
        if (bcnt_q == CW'(1)) state_d = S_MU_END;
      end
      S_MU_END: begin
        cmd_o.op = DP_MUL_DONE;
        ex_d     = {ex_q[W-2:0], 1'b0};
        cnt_d    = cnt_q - 1'b1;
        state_d  = S_SCAN;
      end
      // hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = DP_OUT;
          cmd_o.res   = sts_i.m_zero ? RES_ZERO : (ezero_q ? RES_ONE : RES_RUN);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ex_q        <= '0;
      cnt_q       <= '0;
      bcnt_q      <= '0;
      ezero_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ex_q        <= ex_d;
      cnt_q       <= cnt_d;
      bcnt_q      <= bcnt_d;
      ezero_q     <= ezero_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> design/modular_exponentiation_core.sv
// Modular exponentiation: each request carries a base and returns
// base^exponent mod modulus, with modulus and exponent set beforehand through
// the write port (reset values 2 and 1) and cut to their low OPERAND_BITS
// bits, as is the base. Exponent zero gives 1 mod modulus; modulus zero gives
// 0. One request is processed at a time; a finished result waits in the
// output register while the next request is taken. With k = exponent bits
// below its leading one and j = ones among them, a request with a nonzero
// exponent takes k squarings and j multiplications by the reduced base. These
// are done by the single bit-serial modular multiplier (one multiplier bit
// per cycle).
module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i,
  // request in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FIELD_W-1:0] base_i,
  // result out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FIELD_W-1:0] power_o
);

  localparam int W = OPERAND_BITS;

  logic [FIELD_W-1:0] modulus_q;
  logic [FIELD_W-1:0] exponent_q;
  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [W-1:0]       power_w;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= FIELD_W'(2);
      exponent_q <= FIELD_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MODULUS)  modulus_q  <= cfg_wdata_i;
      if (cfg_idx_i == REG_EXPONENT) exponent_q <= cfg_wdata_i;
    end
  end

  mexp_ctrl #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .exponent_i (exponent_q[W-1:0]),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mexp_datapath #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .base_i   (base_i[W-1:0]),
    .modulus_i(modulus_q[W-1:0]),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .power_o  (power_w)
  );

  assign power_o = FIELD_W'(power_w);

endmodule
